// ===== rtl/i2csrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2csrp_pkg
// Shared constants, codes and helpers for the I2C slave register pointer.
// ----------------------------------------------------------------------------
package i2csrp_pkg;

    // Default sizing of the register file
    localparam int NUM_REGS_DEF  = 16;
    localparam int REG_BYTES_DEF = 8;

    // Fixed field widths
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LREG_W   = 4;
    localparam int LOFF_W   = 3;
    localparam int ERR_W    = 2;
    localparam int SEL_W    = 4;
    localparam int OFF_W    = 4;
    localparam int CNT_W    = 5;
    localparam int MASK_W   = 16;
    localparam int LEN_TB_W = 63;
    localparam int CFG_IX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_REG_COUNT = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_RO_MASK   = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_LEN_TABLE = 2'd2;

    // Event modes
    localparam logic [MODE_W-1:0] MODE_ADDR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CONF  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RO    = 2'd3;

    // One accepted byte event
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_read;
        logic [BYTE_W-1:0] data_byte;
        logic [LREG_W-1:0] local_register;
        logic [LOFF_W-1:0] local_offset;
    } t_item;

    // Raw length nibble of a register; the top register only has three bits
    function automatic logic [3:0] len_nibble(input logic [LEN_TB_W-1:0] tbl,
                                              input logic [SEL_W-1:0]    sel);
        logic [LEN_TB_W:0] ext;
        ext = {1'b0, tbl};
        return ext[{sel, 2'b00} +: 4];
    endfunction

endpackage

// ===== rtl/i2c_slave_register_pointer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_register_pointer
// Byte-event engine of an I2C slave with a file of multi-byte registers.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Signals                      | Contents
// ---------+-----+------------------------------+-----------------------------
// s_axis   | in  | tvalid/tready/tdata/tuser    | one byte event per word
// m_axis   | out | tvalid/tready/tdata/tuser    | one result word per event
// cfg      | in  | i_cfg_valid/o_cfg_ready      | register index + data
//
// Steps: the accept cycle issues the register file read; the execute state
//   then applies the read-modify-write and loads the result register. The
//   single-port register file access keeps the read and the write apart.
// Stalls: if the result register is still held by m_axis, the event waits in
//   the execute state and s_axis stays not ready until it completes.
// Reset: synchronous, active low; selection, offset, read-only mask, lengths,
//   valid bits clear and count goes to 16. No sweep: unwritten entries read 0.
// Config is ready only while no event is executing.
// ----------------------------------------------------------------------------
module i2c_slave_register_pointer
    import i2csrp_pkg::*;
#(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int REG_BYTES = REG_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Event input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [7:0] data_byte, [11:8] local_register, [14:12] local_offset, [15] zero
    input  logic [15:0]         s_axis_tdata,
    // [1:0] mode, [2] is_read
    input  logic [2:0]          s_axis_tuser,

    // Result output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]          m_axis_tdata,
    // [0] tx_valid, [2:1] error_code
    output logic [2:0]          m_axis_tuser,

    // Configuration write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [LEN_TB_W-1:0] i_cfg_data
);

    localparam int DEPTH = NUM_REGS * REG_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // ------------------------------------------------------------------
    // Control state and held event
    // ------------------------------------------------------------------
    logic             r_state, n_state;
    logic [SEL_W-1:0] r_sel, n_sel;
    logic [OFF_W-1:0] r_off, n_off;
    t_item            r_item;

    logic w_accept;
    logic w_done;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]    r_reg_count;
    logic [MASK_W-1:0]   r_ro_mask;
    logic [LEN_TB_W-1:0] r_len_table;

    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_count <= CNT_W'(16);
            r_ro_mask   <= '0;
            r_len_table <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_REG_COUNT: r_reg_count <= i_cfg_data[CNT_W-1:0];
                CFG_RO_MASK:   r_ro_mask   <= i_cfg_data[MASK_W-1:0];
                CFG_LEN_TABLE: r_len_table <= i_cfg_data;
                default: ;  // unused index, dropped
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // Execute finishes once the result register can take a word
    assign w_done        = (r_state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);

    // ------------------------------------------------------------------
    // Register file: byte memory plus a valid bit per entry
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [BYTE_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic [3:0]        w_nib;
    logic [3:0]        w_len;
    logic [OFF_W-1:0]  w_off_clip;
    logic [AW-1:0]     w_bus_addr;
    logic [AW-1:0]     w_loc_addr;
    logic [CNT_W-1:0]  w_eff_count;
    logic [BYTE_W-1:0] w_rd_byte;

    assign w_nib = len_nibble(r_len_table, r_sel);
    assign w_len = (w_nib > 4'(REG_BYTES)) ? 4'(REG_BYTES) : w_nib;

    // Offset is only used for access while below the length; clip keeps
    // the address inside the array otherwise.
    assign w_off_clip = (int'(r_off) < REG_BYTES) ? r_off : '0;
    assign w_bus_addr = AW'(int'(r_sel) * REG_BYTES + int'(w_off_clip));
    assign w_loc_addr = AW'(int'(r_item.local_register) * REG_BYTES
                            + int'(r_item.local_offset));

    assign w_eff_count = (int'(r_reg_count) > NUM_REGS) ? CNT_W'(NUM_REGS)
                                                        : r_reg_count;
    assign w_rd_byte   = r_rd_vld ? r_rd_data : '0;

    // ------------------------------------------------------------------
    // Execute: decide result and write-back
    // ------------------------------------------------------------------
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic              w_txv;
    logic [BYTE_W-1:0] w_tx;
    logic [ERR_W-1:0]  w_err;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_bus_addr;
        w_txv   = 1'b0;
        w_tx    = '0;
        w_err   = ERR_NONE;
        n_sel   = r_sel;
        n_off   = r_off;
        priority if (r_item.mode == MODE_LOCAL) begin
            if (int'(r_item.local_register) < NUM_REGS
                    && int'(r_item.local_offset) < REG_BYTES) begin
                w_we    = 1'b1;
                w_waddr = w_loc_addr;
            end
        end else if (r_item.mode == MODE_ADDR && !r_item.is_read) begin
            n_sel = '0;
            n_off = '0;
        end else if (r_item.mode == MODE_NONE) begin
            // ignored
        end else if (r_item.is_read) begin
            // read address and read data events behave alike
            priority if (w_len == '0) begin
                w_err = ERR_CONF;
            end else if (r_off >= w_len) begin
                w_txv = 1'b1;
            end else begin
                w_txv = 1'b1;
                w_tx  = w_rd_byte;
                n_off = r_off + 1'b1;
            end
        end else if (r_sel == '0) begin
            if ({1'b0, r_item.data_byte} >= 9'(w_eff_count)) begin
                w_err = ERR_RANGE;
            end else begin
                n_sel = r_item.data_byte[SEL_W-1:0];
            end
        end else if (r_ro_mask[r_sel]) begin
            w_err = ERR_RO;
        end else if (w_len == '0) begin
            w_err = ERR_CONF;
        end else if (r_off < w_len) begin
            w_we  = 1'b1;
            n_off = r_off + 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_EXEC;
            S_EXEC: if (w_done)   n_state = S_IDLE;
            default:              n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_sel <= n_sel;
                r_off <= n_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.mode           <= s_axis_tuser[1:0];
            r_item.is_read        <= s_axis_tuser[2];
            r_item.data_byte      <= s_axis_tdata[7:0];
            r_item.local_register <= s_axis_tdata[11:8];
            r_item.local_offset   <= s_axis_tdata[14:12];
        end
    end

    // Memory: read on accept, write back when the event completes
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_mem[w_bus_addr];
        end
        if (w_done && w_we) begin
            r_mem[w_waddr] <= r_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_rd_vld <= r_vld[w_bus_addr];
            end
            if (w_done && w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic              r_out_valid;
    logic              r_out_txv;
    logic [BYTE_W-1:0] r_out_tx;
    logic [ERR_W-1:0]  r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_txv <= w_txv;
            r_out_tx  <= w_tx;
            r_out_err <= w_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tx;
    assign m_axis_tuser  = {r_out_err, r_out_txv};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted event did not enter execute");

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_sel) < NUM_REGS)
        else $error("selection outside register file");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_off) <= REG_BYTES)
        else $error("byte offset beyond register size");

    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out_txv) |-> (r_out_tx == '0))
        else $error("tx byte nonzero without tx_valid");

    a_tx_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_txv) |-> (r_out_err == ERR_NONE))
        else $error("transmit and error in one result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C slave register pointer.
// ----------------------------------------------------------------------------
// A directed table goes first: reset defaults, pointer selection, range and
// read-only errors, fills and reads past the register length. A long random
// run follows, made mostly of bus-like transfers (address, pointer byte, data
// bytes, repeated-start reads) with local writes and noise mixed in, under
// several register settings. Every event word accepted on s_axis runs through
// a bench-side model of the pointer logic; result words on m_axis are
// compared in order against it. Sender bursts and receiver stalls are random,
// and the receiver blocks for a long stretch twice so the input backs up.
// ----------------------------------------------------------------------------
module tb_top;
    import i2csrp_pkg::*;

    localparam int NUM_REGS    = NUM_REGS_DEF;
    localparam int REG_BYTES   = REG_BYTES_DEF;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;

    // One result word as the bench sees it
    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic [ERR_W-1:0]  error_code;
    } t_reply;

    // One row of the directed table: a settings change or an event word
    typedef struct packed {
        logic                is_cfg;
        logic [CNT_W-1:0]    count;
        logic [MASK_W-1:0]   ro_mask;
        logic [LEN_TB_W-1:0] lens;
        t_item               ev;
        logic                typed;   // want holds the expected reply
        t_reply              want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata  = '0;
    logic [2:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [7:0]          m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IX_W-1:0] i_cfg_index   = CFG_REG_COUNT;
    logic [LEN_TB_W-1:0] i_cfg_data    = '0;

    i2c_slave_register_pointer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bench copy of the settings and the pointer state
    logic [CNT_W-1:0]    cur_count;
    logic [MASK_W-1:0]   cur_ro;
    logic [LEN_TB_W-1:0] cur_lens;
    logic [SEL_W-1:0]    sel_q;
    logic [OFF_W-1:0]    off_q;
    logic [7:0]          shadow_store [0:NUM_REGS*REG_BYTES-1];

    t_reply reply_q [$];      // replies still owed by the block
    int     fail_count  = 0;
    int     results_seen = 0;
    int     words_sent  = 0;
    int     burst_left  = 0;
    int     hold_req    = 0;  // bumped by the sender to ask for a long stall
    int     hold_seen   = 0;
    int     hold_left   = 0;
    int     quiet_cycles = 0;

    // Pointer logic of the block, one event word at a time
    function automatic t_reply serve_event(input t_item ev);
        t_reply      r;
        logic [63:0] wide;
        logic [3:0]  len;
        logic [4:0]  limit;
        r     = '0;
        wide  = {1'b0, cur_lens};
        len   = 4'(wide >> (4 * sel_q));
        if (len > REG_BYTES)
            len = 4'(REG_BYTES);
        limit = (cur_count > NUM_REGS) ? 5'(NUM_REGS) : cur_count;
        if (ev.mode == MODE_LOCAL) begin
            shadow_store[{ev.local_register, ev.local_offset}] = ev.data_byte;
        end else if (ev.mode == MODE_ADDR && !ev.is_read) begin
            sel_q = '0;
            off_q = '0;
        end else if (ev.mode != MODE_NONE) begin
            // read address events behave like read data events
            if (ev.is_read) begin
                if (len == 0) begin
                    r.error_code = ERR_CONF;
                end else begin
                    r.tx_valid = 1'b1;
                    if (off_q < len) begin
                        r.tx_byte = shadow_store[{sel_q, off_q[2:0]}];
                        off_q     = off_q + 1'b1;
                    end
                end
            end else if (sel_q == 0) begin
                // pointer byte
                if (ev.data_byte >= limit)
                    r.error_code = ERR_RANGE;
                else
                    sel_q = ev.data_byte[3:0];
            end else if (cur_ro[sel_q]) begin
                r.error_code = ERR_RO;
            end else if (len == 0) begin
                r.error_code = ERR_CONF;
            end else if (off_q < len) begin
                shadow_store[{sel_q, off_q[2:0]}] = ev.data_byte;
                off_q = off_q + 1'b1;
            end
            // writes past the length are dropped silently
        end
        return r;
    endfunction

    function automatic t_item byte_event(input logic [1:0] m, input logic rd,
                                         input logic [7:0] d, input logic [3:0] lr,
                                         input logic [2:0] lo);
        return {m, rd, d, lr, lo};
    endfunction

    function automatic t_reply reply(input logic v, input logic [7:0] b,
                                     input logic [1:0] e);
        return {v, b, e};
    endfunction

    function automatic t_row event_row(input t_item ev, input logic typed,
                                       input t_reply want);
        t_row row;
        row       = '0;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic t_row settings_row(input logic [4:0] cnt, input logic [15:0] msk,
                                          input logic [62:0] lens);
        t_row row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.count   = cnt;
        row.ro_mask = msk;
        row.lens    = lens;
        return row;
    endfunction

    // Lengths mostly 1..8, with some zero and oversize nibbles
    function automatic logic [62:0] random_lengths();
        logic [63:0] t;
        int          r;
        t = '0;
        for (r = 0; r < NUM_REGS; r++)
            t[4*r +: 4] = ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                                     : 4'($urandom_range(1, REG_BYTES));
        return t[62:0];
    endfunction

    // Offer one event word; the sender idles between bursts
    task automatic send_event(input t_item ev, input logic typed, input t_reply want);
        t_reply guess;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, ev.local_offset, ev.local_register, ev.data_byte};
        s_axis_tuser  <= {ev.is_read, ev.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        guess = serve_event(ev);
        reply_q.push_back(typed ? want : guess);
        words_sent++;
    endtask

    task automatic send_random(input logic [1:0] m, input logic rd, input logic [7:0] d);
        send_event(byte_event(m, rd, d, 4'($urandom), 3'($urandom)), 1'b0, '0);
    endtask

    // Settings only change with the block drained
    task automatic apply_settings(input logic [4:0] cnt, input logic [15:0] msk,
                                  input logic [62:0] lens);
        int ix;
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        for (ix = 0; ix < 3; ix++) begin
            case (ix)
                0: begin
                    i_cfg_index <= CFG_REG_COUNT;
                    i_cfg_data  <= 63'(cnt);
                end
                1: begin
                    i_cfg_index <= CFG_RO_MASK;
                    i_cfg_data  <= 63'(msk);
                end
                default: begin
                    i_cfg_index <= CFG_LEN_TABLE;
                    i_cfg_data  <= lens;
                end
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_count  = cnt;
        cur_ro     = msk;
        cur_lens   = lens;
        burst_left = 0;
    endtask

    // Receiver: stall style changes whenever the 8-bit tick wraps, long holds on request
    logic [1:0] rx_style = 2'd0;
    logic [7:0] rx_tick  = '0;

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == 8'hFF)
            rx_style <= 2'($urandom);
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom);
                2'd2:    m_axis_tready <= (rx_tick[1:0] == 2'd3);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end

        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata, m_axis_tuser[2:1]};
            results_seen++;
            if (reply_q.size() == 0) begin
                if (fail_count < 10)
                    $display("word %0d: result with nothing pending (valid=%0b byte=%02h err=%0d)",
                             results_seen, got.tx_valid, got.tx_byte, got.error_code);
                fail_count++;
            end else begin
                want = reply_q.pop_front();
                if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                    got.error_code !== want.error_code) begin
                    if (fail_count < 10)
                        $display("word %0d: expected valid=%0b byte=%02h err=%0d, got valid=%0b byte=%02h err=%0d",
                                 results_seen, want.tx_valid, want.tx_byte, want.error_code,
                                 got.tx_valid, got.tx_byte, got.error_code);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        t_row        plan [$];
        int          i;
        int          phase;
        int          phase_start;
        int          n;
        int          pick;
        logic [4:0]  cnt;
        logic [15:0] msk;
        logic [62:0] lens;

        cur_count = 5'd16;
        cur_ro    = '0;
        cur_lens  = '0;
        sel_q     = '0;
        off_q     = '0;
        for (i = 0; i < NUM_REGS * REG_BYTES; i++)
            shadow_store[i] = 8'h00;

        // Reset defaults: every length is zero, sixteen registers
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b1, 8'h00, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_CONF)));
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b0, 8'hFF, 4'hF, 3'd7), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h10, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_RANGE)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'hFF, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_RANGE)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h00, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h05, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'hAA, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_CONF)));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b1, 8'h00, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_CONF)));
        plan.push_back(event_row(byte_event(MODE_NONE, 1'b1, 8'hFF, 4'hF, 3'd7), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_LOCAL, 1'b0, 8'hA5, 4'd5, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_LOCAL, 1'b1, 8'hFF, 4'hF, 3'd7), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        plan.push_back(event_row(byte_event(MODE_LOCAL, 1'b0, 8'h00, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_NONE)));
        // Lengths: r1 8, r2 oversize, r3 2, r5 3, r15 7; r4 and r15 read-only
        plan.push_back(settings_row(5'd16, 16'h8010, 63'h7000_0000_0030_2F80));
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b0, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h05, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h11, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h22, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h33, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h44, 4'd0, 3'd0), 1'b0, '0));
        // read past the length, then restart and read back
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b1, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b0, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h05, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b1, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b1, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        // read-only wins over a zero length
        plan.push_back(event_row(byte_event(MODE_ADDR, 1'b0, 8'h00, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h04, 4'd0, 3'd0), 1'b0, '0));
        plan.push_back(event_row(byte_event(MODE_DATA, 1'b0, 8'h77, 4'd0, 3'd0), 1'b1,
                                 reply(1'b0, 8'h00, ERR_RO)));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                apply_settings(plan[i].count, plan[i].ro_mask, plan[i].lens);
            else
                send_event(plan[i].ev, plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    cnt  = 5'd16;
                    msk  = 16'h0000;
                    lens = '1;
                end
                1: begin
                    cnt  = 5'd0;
                    msk  = 16'hFFFF;
                    lens = '0;
                end
                2: begin
                    cnt  = 5'd31;
                    msk  = 16'($urandom);
                    lens = random_lengths();
                end
                3: begin
                    cnt  = 5'd1;
                    msk  = 16'h0000;
                    lens = random_lengths();
                end
                default: begin
                    cnt  = 5'($urandom_range(2, 17));
                    msk  = 16'($urandom & $urandom);
                    lens = random_lengths();
                end
            endcase
            apply_settings(cnt, msk, lens);
            // long receiver hold while words keep coming
            if (phase == 2 || phase == 5)
                hold_req <= hold_req + 1;

            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    // write transfer: pointer byte, data bytes, maybe a read-back
                    send_random(MODE_ADDR, 1'b0, 8'($urandom));
                    send_random(MODE_DATA, 1'b0,
                                ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                            : 8'($urandom_range(0, 15)));
                    n = $urandom_range(0, 10);
                    repeat (n) send_random(MODE_DATA, 1'b0, 8'($urandom));
                    if ($urandom_range(0, 2) == 0) begin
                        send_random(MODE_ADDR, 1'b1, 8'($urandom));
                        n = $urandom_range(0, 9);
                        repeat (n) send_random(MODE_DATA, 1'b1, 8'($urandom));
                    end
                end else if (pick < 15) begin
                    // read transfer from the current pointer
                    send_random(MODE_ADDR, 1'b1, 8'($urandom));
                    n = $urandom_range(0, 9);
                    repeat (n) send_random(MODE_DATA, 1'b1, 8'($urandom));
                end else if (pick < 18) begin
                    n = $urandom_range(1, 8);
                    repeat (n) send_random(MODE_LOCAL, 1'($urandom), 8'($urandom));
                end else begin
                    send_random(2'($urandom), 1'($urandom), 8'($urandom));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (reply_q.size() != 0)
            $display("%0d expected results never arrived", reply_q.size());
        if (fail_count == 0 && reply_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
